[rtl/upd_pkg.sv]
package upd_pkg;

    // One transaction on the input channel.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    // One transaction on the output channel.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out;

    // Decoded bytes produced by one input byte, in order bytes[0], bytes[1], bytes[2].
    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][7:0] bytes;
        logic            last;
    } t_pkt;

    // Status of the packet queue as seen by its neighbors.
    typedef struct packed {
        logic full;
        logic valid;
    } t_q_stat;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_PCT  = 3'b010,
        PH_DIG  = 3'b100
    } t_phase;

    localparam logic [7:0] C_PCT   = 8'h25;
    localparam logic [7:0] C_PLUS  = 8'h2B;
    localparam logic [7:0] C_SPACE = 8'h20;

    // Returns {is_digit, value} for an uppercase hex digit.
    function automatic logic [4:0] hex_upper(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    // First digits that may begin a decodable escape.
    function automatic logic can_start(input logic [7:0] c);
        return (c == 8'h32) || (c == 8'h33) || (c == 8'h34) ||
               (c == 8'h35) || (c == 8'h37);
    endfunction

    // Escape codes that are replaced by their byte value.
    function automatic logic listed(input logic [7:0] v);
        return (v == 8'h20) ||
               (v >= 8'h22 && v <= 8'h29) ||
               (v == 8'h2B) || (v == 8'h2C) || (v == 8'h2F) ||
               (v >= 8'h3A && v <= 8'h3E) ||
               (v == 8'h40) ||
               (v == 8'h5B) || (v == 8'h5D) || (v == 8'h5E) ||
               (v >= 8'h7B && v <= 8'h7D);
    endfunction

endpackage

[rtl/upd_front.sv]
module upd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  upd_pkg::t_in  i_in,
    input  logic          i_q_full,
    output logic          o_stall,
    output logic          o_push,
    output upd_pkg::t_pkt o_pkt,
    output logic          o_pending
);
    import upd_pkg::*;

    t_phase     r_phase;
    t_phase     n_phase;
    logic [7:0] r_held;
    logic [7:0] n_held;

    logic            accept;
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
    logic            run_idle;
    logic [4:0]      hi;
    logic [4:0]      lo;
    logic [7:0]      code;
    logic [7:0]      b;

    assign b      = i_in.in_byte;
    assign hi     = hex_upper(r_held);
    assign lo     = hex_upper(b);
    assign code   = {hi[3:0], lo[3:0]};
    assign accept = i_valid && !i_q_full;

    always_comb begin
        n_phase  = r_phase;
        n_held   = r_held;
        cnt      = '0;
        bytes    = '0;
        run_idle = 1'b0;

        unique case (r_phase)
            PH_PCT: begin
                if (can_start(b)) begin
                    n_held  = b;
                    n_phase = PH_DIG;
                end else begin
                    bytes[0] = C_PCT;
                    cnt      = 2'd1;
                    run_idle = 1'b1;
                end
            end
            PH_DIG: begin
                if (hi[4] && lo[4] && listed(code)) begin
                    bytes[0] = code;
                    cnt      = 2'd1;
                    n_phase  = PH_IDLE;
                end else begin
                    bytes[0] = C_PCT;
                    bytes[1] = r_held;
                    cnt      = 2'd2;
                    run_idle = 1'b1;
                end
            end
            default: begin
                run_idle = 1'b1;
            end
        endcase

        if (run_idle) begin
            if (b == C_PCT) begin
                n_phase = PH_PCT;
            end else begin
                bytes[cnt] = (b == C_PLUS) ? C_SPACE : b;
                cnt        = cnt + 2'd1;
                n_phase    = PH_IDLE;
            end
        end

        // End of string: flush whatever escape is still open.
        if (i_in.in_last) begin
            if (n_phase == PH_PCT) begin
                bytes[cnt] = C_PCT;
                cnt        = cnt + 2'd1;
            end else if (n_phase == PH_DIG) begin
                bytes[cnt]        = C_PCT;
                bytes[cnt + 2'd1] = n_held;
                cnt               = cnt + 2'd2;
            end
            n_phase = PH_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

    assign o_stall    = i_q_full;
    assign o_push     = accept && (cnt != 2'd0);
    assign o_pkt.cnt   = cnt;
    assign o_pkt.bytes = bytes;
    assign o_pkt.last  = i_in.in_last;
    assign o_pending  = (r_phase != PH_IDLE);

endmodule

[rtl/upd_queue.sv]
module upd_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  upd_pkg::t_pkt    i_pkt,
    input  logic             i_pop,
    output upd_pkg::t_pkt    o_head,
    output upd_pkg::t_q_stat o_stat
);
    import upd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_pkt          mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr;
    logic [PW-1:0] n_rd;

    assign n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[r_wr] <= i_pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_head       = mem[r_rd];
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.valid = (r_count != '0);

endmodule

[rtl/upd_back.sv]
module upd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  upd_pkg::t_q_stat i_q_stat,
    input  upd_pkg::t_pkt    i_q_head,
    input  logic             i_out_stall,
    output logic             o_pop,
    output logic             o_out_valid,
    output upd_pkg::t_out    o_out_data
);
    import upd_pkg::*;

    logic       r_busy;
    t_pkt       r_pkt;
    logic [1:0] r_idx;
    logic       r_out_valid;
    t_out       r_out_data;

    logic       out_ready;
    logic       take;
    logic       is_end;
    logic       done;
    logic [7:0] cur_byte;

    assign out_ready = !r_out_valid || !i_out_stall;
    assign take      = r_busy && out_ready;
    assign is_end    = (r_idx == r_pkt.cnt - 2'd1);
    assign done      = take && is_end;
    assign o_pop     = i_q_stat.valid && (!r_busy || done);

    always_comb begin
        unique case (r_idx)
            2'd0:    cur_byte = r_pkt.bytes[0];
            2'd1:    cur_byte = r_pkt.bytes[1];
            default: cur_byte = r_pkt.bytes[2];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_ready) begin
                r_out_valid <= take;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (done) begin
                r_busy <= 1'b0;
            end else if (take) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pkt <= i_q_head;
        end
        if (take) begin
            r_out_data.out_byte <= cur_byte;
            r_out_data.out_last <= r_pkt.last && is_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[rtl/url_percent_decoder.sv]
// Path: the first decoded byte of an input transaction passes through the packet queue,
//   the serializer's packet register and the registered output stage.
// Throughput: one output byte per cycle unless the output stalls; the serializer
//   emits the bytes of one packet in turn, so the input stalls only when the queue fills.
// Reset: synchronous, active low; clears the escape state, the queue and the output.
module url_percent_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  upd_pkg::t_in  i_in_data,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output upd_pkg::t_out o_out_data,
    input  logic          i_out_stall
);
    import upd_pkg::*;

    // The front end tracks the escape state (idle, after a percent sign, after a
    // percent sign and a first digit) and turns every accepted input transaction into a
    // packet of zero to three decoded bytes. Empty packets are dropped at the source.
    // The queue decouples the front end from the serializer, which emits one byte per
    // cycle while the output is not stalled, through a registered output stage.

    logic    w_push;
    t_pkt    w_pkt;
    logic    w_pop;
    t_pkt    w_head;
    t_q_stat w_q_stat;
    logic    w_pending;

    upd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_in      (i_in_data),
        .i_q_full  (w_q_stat.full),
        .o_stall   (o_in_stall),
        .o_push    (w_push),
        .o_pkt     (w_pkt),
        .o_pending (w_pending)
    );

    upd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pkt   (w_pkt),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    upd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (w_q_stat),
        .i_q_head    (w_head),
        .i_out_stall (i_out_stall),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

`ifndef ASSERT_OFF
    // A packet must never be written into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_stat.full)
        else $error("packet pushed into a full queue");

    // The serializer only takes a packet that is really there.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_stat.valid)
        else $error("packet popped from an empty queue");

    // Every packet handed to the serializer carries at least one byte.
    a_pkt_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (w_head.cnt != 2'd0))
        else $error("empty packet reached the serializer");

    // The end of a string always closes any open escape.
    a_last_flushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_data.in_last) |=> !w_pending)
        else $error("escape still pending after the last byte of a string");
`endif

endmodule

[dv/tb_top.sv]
module tb_top;

    import upd_pkg::*;

    // Run length guard.
    localparam int CYCLE_LIMIT   = 200000;
    localparam int IDLE_PERCENT  = 7;
    localparam int RANDOM_ITEMS  = 450;
    localparam int HOLD_CYCLES   = 60;
    localparam int HOLD_TRIGGER  = 100;
    localparam int DRAIN_CYCLES  = 20;
    localparam int REPORT_LIMIT  = 10;

    // The 24 escape codes that the decoder replaces by their byte value.
    logic [7:0] decodable_codes [24] = '{
        8'h20, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29,
        8'h2B, 8'h2C, 8'h2F, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h40,
        8'h5B, 8'h5D, 8'h5E, 8'h7B, 8'h7C, 8'h7D
    };

    // ASCII digits that can begin one of the codes above.
    logic [7:0] lead_digits [5] = '{8'h32, 8'h33, 8'h34, 8'h35, 8'h37};

    logic  i_clk       = 1'b0;
    logic  i_rst_n     = 1'b0;
    logic  i_in_valid  = 1'b0;
    t_in   i_in_data   = '0;
    logic  o_in_stall;
    logic  o_out_valid;
    t_out  o_out_data;
    logic  i_out_stall = 1'b0;

    url_percent_decoder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    always #10 i_clk = ~i_clk;

    // Raw bytes waiting to be offered, and decoded bytes the block still owes us.
    t_in    pending_bytes [$];
    t_out   decoded_expect [$];

    // Our own copy of the escape state, advanced once per accepted transaction.
    t_phase     dec_phase = PH_IDLE;
    logic [7:0] dec_held  = '0;

    logic in_taken    = 1'b0;
    int   outs_seen   = 0;
    int   sent_count  = 0;
    int   hold_left   = 0;
    logic hold_done   = 1'b0;
    int   err_count   = 0;

    // Returns {is_digit, value}. Only uppercase hex digits count as digits.
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return {1'b1, c[3:0]};
        if (c >= 8'h41 && c <= 8'h46) return {1'b1, c[3:0] + 4'd9};
        return 5'd0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input logic lower);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return (lower ? 8'h57 : 8'h37) + 8'(n);
    endfunction

    // Works out the decoded bytes caused by one raw byte and queues them.
    task automatic predict_decode(input t_in item);
        logic [7:0] res [3];
        int         n;
        logic       plain;
        logic       hit;
        logic [4:0] hi;
        logic [4:0] lo;
        logic [7:0] code;
        t_out       e;
        n     = 0;
        plain = 1'b0;
        case (dec_phase)
            PH_PCT: begin
                // Only a digit that can start a listed code keeps the escape alive.
                if (item.in_byte == 8'h32 || item.in_byte == 8'h33 || item.in_byte == 8'h34 ||
                    item.in_byte == 8'h35 || item.in_byte == 8'h37) begin
                    dec_held  = item.in_byte;
                    dec_phase = PH_DIG;
                end else begin
                    res[n] = C_PCT;
                    n++;
                    plain = 1'b1;
                end
            end
            PH_DIG: begin
                hi   = nibble_of(dec_held);
                lo   = nibble_of(item.in_byte);
                code = {hi[3:0], lo[3:0]};
                hit  = 1'b0;
                if (hi[4] && lo[4]) begin
                    foreach (decodable_codes[k]) begin
                        if (decodable_codes[k] == code) hit = 1'b1;
                    end
                end
                if (hit) begin
                    res[n] = code;
                    n++;
                    dec_phase = PH_IDLE;
                end else begin
                    // Not a listed code: the escape goes out verbatim.
                    res[n] = C_PCT;
                    n++;
                    res[n] = dec_held;
                    n++;
                    plain = 1'b1;
                end
            end
            default: begin
                plain = 1'b1;
            end
        endcase
        // The byte is taken as if no escape were pending.
        if (plain) begin
            dec_phase = PH_IDLE;
            if (item.in_byte == C_PCT) begin
                dec_phase = PH_PCT;
            end else begin
                res[n] = (item.in_byte == C_PLUS) ? C_SPACE : item.in_byte;
                n++;
            end
        end
        // The end of a string flushes whatever escape is still open.
        if (item.in_last) begin
            if (dec_phase == PH_PCT) begin
                res[n] = C_PCT;
                n++;
            end else if (dec_phase == PH_DIG) begin
                res[n] = C_PCT;
                n++;
                res[n] = dec_held;
                n++;
            end
            dec_phase = PH_IDLE;
        end
        for (int k = 0; k < n; k++) begin
            e.out_byte = res[k];
            e.out_last = item.in_last && (k == n - 1);
            decoded_expect.push_back(e);
        end
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic last);
        t_in item;
        item.in_byte = b;
        item.in_last = last;
        pending_bytes.push_back(item);
    endtask

    task automatic queue_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            queue_byte(s[k], k == s.len() - 1);
        end
    endtask

    // One random string. Well-formed escapes are the commonest segment, with broken
    // and truncated escapes, lowercase hex, plus signs and arbitrary bytes mixed in.
    task automatic queue_random_text();
        logic [7:0] text [$];
        int         segs;
        int         pick;
        logic [7:0] code;
        logic [7:0] lead;
        segs = $urandom_range(1, 8);
        repeat (segs) begin
            pick = $urandom_range(0, 99);
            code = decodable_codes[$urandom_range(0, 23)];
            lead = lead_digits[$urandom_range(0, 4)];
            if (pick < 45) begin
                text.push_back(C_PCT);
                text.push_back(hex_char(code[7:4], 1'b0));
                text.push_back(hex_char(code[3:0], 1'b0));
            end else if (pick < 55) begin
                text.push_back(C_PLUS);
            end else if (pick < 62) begin
                text.push_back(C_PCT);
                text.push_back(lead);
                text.push_back(8'($urandom_range(0, 255)));
            end else if (pick < 68) begin
                text.push_back(C_PCT);
                text.push_back(hex_char(code[7:4], 1'b1));
                text.push_back(hex_char(code[3:0], 1'b1));
            end else if (pick < 78) begin
                text.push_back(8'($urandom_range(0, 255)));
            end else if (pick < 83) begin
                text.push_back(C_PCT);
            end else if (pick < 88) begin
                text.push_back(C_PCT);
                text.push_back(lead);
            end else begin
                text.push_back(8'($urandom_range(8'h61, 8'h7A)));
            end
        end
        foreach (text[k]) queue_byte(text[k], k == text.size() - 1);
    endtask

    // Monitor. Both channels are sampled at the rising edge, where the block's
    // registered outputs still show their values from before the edge. The
    // outgoing transaction is checked first, then the incoming one is predicted.
    always @(posedge i_clk) begin
        t_out e;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                outs_seen <= outs_seen + 1;
                if (decoded_expect.size() == 0) begin
                    if (err_count < REPORT_LIMIT) begin
                        $display("unexpected transaction: byte %02h last %0b",
                                 o_out_data.out_byte, o_out_data.out_last);
                    end
                    err_count++;
                end else begin
                    e = decoded_expect.pop_front();
                    if (o_out_data.out_byte !== e.out_byte ||
                        o_out_data.out_last !== e.out_last) begin
                        if (err_count < REPORT_LIMIT) begin
                            $display("mismatch on result %0d: expected byte %02h last %0b, got byte %02h last %0b",
                                     outs_seen, e.out_byte, e.out_last,
                                     o_out_data.out_byte, o_out_data.out_last);
                        end
                        err_count++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                predict_decode(i_in_data);
            end
            in_taken <= i_in_valid && !o_in_stall;
        end
    end

    // Driver. A new transaction is presented at the falling edge once the
    // previous one has been taken. It idles now and then, except while a
    // calm window is open or the receiver is holding off, so that the block
    // keeps getting input and fills up.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (pending_bytes.size() > 0 &&
                (hold_left > 0 || (sent_count >= 150 && sent_count < 260) ||
                 $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                i_in_data  <= pending_bytes.pop_front();
                i_in_valid <= 1'b1;
                sent_count <= sent_count + 1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver. Random stalls, a calm window with none, and one long hold-off
    // during which the block's queue must fill and stall its input.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (!hold_done && outs_seen >= HOLD_TRIGGER) begin
            i_out_stall <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            hold_done   <= 1'b1;
        end else if (outs_seen >= 300 && outs_seen < 450) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        // Directed strings: the byte extremes, plus to space, listed codes,
        // a decoded percent that must not be decoded again, lowercase hex,
        // broken escapes and escapes cut off by the end of a string.
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b1);
        queue_text("%2B+");
        queue_text("%25%2");
        queue_text("%7D%5b");
        queue_text("%%+");
        queue_text("%2q");
        queue_text("%");
        begin
            int target;
            target = pending_bytes.size() + RANDOM_ITEMS;
            while (pending_bytes.size() < target) queue_random_text();
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_bytes.size() > 0 || i_in_valid) @(posedge i_clk);
        while (decoded_expect.size() > 0) @(posedge i_clk);
        // Give any stray extra transaction the chance to show up.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/upd_pkg.sv
rtl/upd_front.sv
rtl/upd_queue.sv
rtl/upd_back.sv
rtl/url_percent_decoder.sv
dv/tb_top.sv
